// File: rtl/cctmix_pkg.sv
`default_nettype none

package cctmix_pkg;

  // Field widths
  localparam int KELVIN_W = 14;
  localparam int BRI_W    = 8;
  localparam int LVL_W    = 7;
  localparam int DUTY_W   = 8;
  localparam int OP_W     = 2;
  localparam int CFG_W    = 14;
  localparam int IDX_W    = 2;

  // Divider widths: level*255*diff + span*50 fits in 30 bits, 100*span in 21,
  // and the rounded ratio stays below 512.
  localparam int NUM_W = 30;
  localparam int DEN_W = 21;
  localparam int QUO_W = 9;

  // Arithmetic constants
  localparam int DUTY_FULL = 255;
  localparam int PCT_FULL  = 100;
  localparam int PCT_HALF  = 50;
  localparam int SLOW_SUM  = 40;

  // Reset values
  localparam logic [KELVIN_W-1:0] WARM_RST    = KELVIN_W'(2700);
  localparam logic [KELVIN_W-1:0] COOL_RST    = KELVIN_W'(6500);
  localparam logic [LVL_W-1:0]    MIN_BRI_RST = LVL_W'(5);
  localparam logic [LVL_W-1:0]    APP_BRI_RST = LVL_W'(100);

  // Item codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_OFF  = 2'd2
  } op_t;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_WARM    = 2'd0,
    REG_COOL    = 2'd1,
    REG_MIN_BRI = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/cct_led_mixer_fader_core.sv
`default_nettype none

// Channel   Handshake                  Payload
// req       req_valid / req_stall      op, kelvin, brightness
// res       res_valid / res_stall      duty_cool, duty_warm, changed, slow_hold,
//                                      done_res, lamp_on, app_kelvin_out,
//                                      app_brightness_out
// cfg       cfg_we (no handshake)      cfg_index, cfg_data
//
// A tick with a fade pending passes through a prep step, then per channel a
// multiply step, a divider load, a restoring divide and the take of the
// quotient, then a step that moves the duties and the result step. Both
// channels use the single shared divider; the next item is taken once the
// result has been loaded into the output register.
// Set, off, idle tick and unused codes go straight to the result step.
// One item at a time.
// Reset (rst, synchronous) restores the register defaults and clears the fade.
// A stalled result sits in the output register; the next item is taken and
// worked on, and only its result load waits for the register to free up.
module cct_led_mixer_fader_core (
  input  wire                                 clk,
  input  wire                                 rst,
  // configuration
  input  wire                                 cfg_we,
  input  wire  [cctmix_pkg::IDX_W-1:0]        cfg_index,
  input  wire  [cctmix_pkg::CFG_W-1:0]        cfg_data,
  // request channel
  input  wire                                 req_valid,
  output logic                                req_stall,
  input  wire  [cctmix_pkg::OP_W-1:0]         op,
  input  wire  [cctmix_pkg::KELVIN_W-1:0]     kelvin,
  input  wire  [cctmix_pkg::BRI_W-1:0]        brightness,
  // result channel
  output logic                                res_valid,
  input  wire                                 res_stall,
  output logic [cctmix_pkg::DUTY_W-1:0]       duty_cool,
  output logic [cctmix_pkg::DUTY_W-1:0]       duty_warm,
  output logic                                changed,
  output logic                                slow_hold,
  output logic                                done_res,
  output logic                                lamp_on,
  output logic [cctmix_pkg::KELVIN_W-1:0]     app_kelvin_out,
  output logic [cctmix_pkg::LVL_W-1:0]        app_brightness_out
);

  localparam int KW = cctmix_pkg::KELVIN_W;
  localparam int LW = cctmix_pkg::LVL_W;
  localparam int DW = cctmix_pkg::DUTY_W;
  localparam int NW = cctmix_pkg::NUM_W;
  localparam int EW = cctmix_pkg::DEN_W;
  localparam int QW = cctmix_pkg::QUO_W;
  localparam int PW = LW + 8;  // level * 255

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_STEP,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [KW-1:0] warm_kelvin;
  logic [KW-1:0] cool_kelvin;
  logic [LW-1:0] min_brightness;

  // fade state
  logic [KW-1:0] app_kelvin;
  logic [LW-1:0] app_brightness;
  logic [KW-1:0] target_kelvin;
  logic [LW-1:0] target_level;
  logic          fade_pending;
  logic [DW-1:0] cool_now;
  logic [DW-1:0] warm_now;
  logic          on_flag;

  // datapath registers for one tick
  logic [KW-1:0] span;
  logic [KW-1:0] dcool;
  logic [KW-1:0] dwarm;
  logic [PW-1:0] lvl255;
  logic          chan;       // 0 cool, 1 warm
  logic [DW-1:0] tgt_cool;
  logic [DW-1:0] tgt_warm;

  // staged result flags
  logic          p_changed;
  logic          p_slow;
  logic          p_done;
  logic          p_lamp;
  logic [KW-1:0] p_kout;
  logic [LW-1:0] p_bout;

  cctmix_pkg::div_req_t div_req;
  cctmix_pkg::div_rsp_t div_rsp;

  cctmix_div #(
    .NUM_W (NW),
    .DEN_W (EW),
    .QUO_W (QW)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ------------------------------------------------------------------
  // Request decode
  // ------------------------------------------------------------------
  logic          req_acc;
  logic          res_free;
  logic [LW-1:0] app_bri_next;
  logic [KW-1:0] app_kel_next;
  logic [LW-1:0] set_level;

  localparam logic [cctmix_pkg::BRI_W-1:0] BRI_W_ONE  = cctmix_pkg::BRI_W'(1);
  localparam logic [cctmix_pkg::BRI_W-1:0] BRI_W_FULL = cctmix_pkg::BRI_W'(cctmix_pkg::PCT_FULL);

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  always_comb begin
    app_kel_next = app_kelvin;
    if (kelvin >= warm_kelvin && kelvin <= cool_kelvin) begin
      app_kel_next = kelvin;
    end
    app_bri_next = app_brightness;
    if (brightness >= BRI_W_ONE && brightness <= BRI_W_FULL) begin
      app_bri_next = brightness[LW-1:0];
    end
    // raise a nonzero request to the floor
    if (app_bri_next != '0 && app_bri_next <= min_brightness) begin
      set_level = min_brightness;
    end else begin
      set_level = app_bri_next;
    end
  end

  // ------------------------------------------------------------------
  // Prep: clamp kelvin, pick diffs; empty span maps to span 1, cool 0, warm 1
  // ------------------------------------------------------------------
  logic          span_empty;
  logic [KW-1:0] kk;

  assign span_empty = (cool_kelvin <= warm_kelvin);

  always_comb begin
    kk = target_kelvin;
    if (target_kelvin < warm_kelvin) begin
      kk = warm_kelvin;
    end else if (target_kelvin > cool_kelvin) begin
      kk = cool_kelvin;
    end
  end

  // ------------------------------------------------------------------
  // Multiply: num = level*255*diff + 50*span, den = 100*span
  // ------------------------------------------------------------------
  logic [KW-1:0] dsel;
  logic [NW-1:0] num_calc;
  logic [EW-1:0] den_calc;

  assign dsel     = chan ? dwarm : dcool;
  assign num_calc = NW'(lvl255) * NW'(dsel) + NW'(span) * NW'(cctmix_pkg::PCT_HALF);
  assign den_calc = EW'(span) * EW'(cctmix_pkg::PCT_FULL);

  logic [DW-1:0] quo_sat;
  assign quo_sat = (div_rsp.quo > QW'(cctmix_pkg::DUTY_FULL)) ? DW'(cctmix_pkg::DUTY_FULL)
                                                              : div_rsp.quo[DW-1:0];

  // ------------------------------------------------------------------
  // Step: move each duty one count toward its target
  // ------------------------------------------------------------------
  logic [DW-1:0] cool_step;
  logic [DW-1:0] warm_step;
  logic          moved;
  logic [DW:0]   duty_sum;

  always_comb begin
    cool_step = cool_now;
    warm_step = warm_now;
    if (cool_now > tgt_cool) begin
      cool_step = cool_now - DW'(1);
    end else if (cool_now < tgt_cool) begin
      cool_step = cool_now + DW'(1);
    end
    if (warm_now > tgt_warm) begin
      warm_step = warm_now - DW'(1);
    end else if (warm_now < tgt_warm) begin
      warm_step = warm_now + DW'(1);
    end
    moved    = (cool_step != cool_now) || (warm_step != warm_now);
    duty_sum = (DW+1)'(cool_step) + (DW+1)'(warm_step);
  end

  // ------------------------------------------------------------------
  // Sequencer, state and result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      warm_kelvin    <= cctmix_pkg::WARM_RST;
      cool_kelvin    <= cctmix_pkg::COOL_RST;
      min_brightness <= cctmix_pkg::MIN_BRI_RST;
      app_kelvin     <= cctmix_pkg::WARM_RST;
      app_brightness <= cctmix_pkg::APP_BRI_RST;
      target_kelvin  <= cctmix_pkg::WARM_RST;
      target_level   <= '0;
      fade_pending   <= 1'b0;
      cool_now       <= '0;
      warm_now       <= '0;
      on_flag        <= 1'b0;
      res_valid      <= 1'b0;
      div_req.start  <= 1'b0;
      chan           <= 1'b0;
    end else begin
      // start the divider on the cycle after a multiply
      div_req.start <= (state == S_MUL);

      // drop the result once taken
      if (res_valid && !res_stall && state != S_EMIT) begin
        res_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          cctmix_pkg::REG_WARM:    warm_kelvin    <= cfg_data[KW-1:0];
          cctmix_pkg::REG_COOL:    cool_kelvin    <= cfg_data[KW-1:0];
          cctmix_pkg::REG_MIN_BRI: min_brightness <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            p_changed <= 1'b0;
            p_slow    <= 1'b0;
            p_done    <= 1'b0;
            p_lamp    <= 1'b0;
            p_kout    <= '0;
            p_bout    <= '0;
            // a tick with a fade pending goes through the datapath
            if (op == cctmix_pkg::OP_TICK && fade_pending) begin
              state <= S_PREP;
            end else begin
              state <= S_EMIT;
            end
            case (op)
              cctmix_pkg::OP_SET: begin
                app_kelvin     <= app_kel_next;
                app_brightness <= app_bri_next;
                target_kelvin  <= app_kel_next;
                target_level   <= set_level;
                fade_pending   <= 1'b1;
              end
              cctmix_pkg::OP_OFF: begin
                target_kelvin <= app_kelvin;
                target_level  <= '0;
                fade_pending  <= 1'b1;
              end
              default: ;  // tick, or unused code: same as an idle tick
            endcase
          end
        end

        S_PREP: begin
          lvl255 <= (PW'(target_level) << 8) - PW'(target_level);
          chan   <= 1'b0;
          if (span_empty) begin
            span  <= KW'(1);
            dcool <= '0;
            dwarm <= KW'(1);
          end else begin
            span  <= cool_kelvin - warm_kelvin;
            dcool <= kk - warm_kelvin;
            dwarm <= cool_kelvin - kk;
          end
          state <= S_MUL;
        end

        S_MUL: begin
          div_req.num   <= num_calc;
          div_req.den   <= den_calc;
          state         <= S_DIV;
        end

        S_DIV: begin
          if (div_rsp.done) begin
            if (!chan) begin
              tgt_cool <= quo_sat;
              chan     <= 1'b1;
              state    <= S_MUL;
            end else begin
              tgt_warm <= quo_sat;
              state    <= S_STEP;
            end
          end
        end

        S_STEP: begin
          cool_now <= cool_step;
          warm_now <= warm_step;
          if (moved) begin
            p_changed <= 1'b1;
            p_slow    <= (duty_sum < (DW+1)'(cctmix_pkg::SLOW_SUM));
          end else begin
            // fade settled: report the kept request
            fade_pending <= 1'b0;
            on_flag      <= (target_level != '0);
            p_done       <= 1'b1;
            p_lamp       <= (target_level != '0);
            p_kout       <= app_kelvin;
            p_bout       <= app_brightness;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          // hold until the result register is free
          if (res_free) begin
            res_valid          <= 1'b1;
            duty_cool          <= cool_now;
            duty_warm          <= warm_now;
            changed            <= p_changed;
            slow_hold          <= p_slow;
            done_res           <= p_done;
            lamp_on            <= p_lamp;
            app_kelvin_out     <= p_kout;
            app_brightness_out <= p_bout;
            state              <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slow_needs_change: assert property (@(posedge clk) disable iff (rst)
    res_valid && slow_hold |-> changed)
    else $error("slow_hold without a duty change");

  a_done_excl_change: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(done_res && changed))
    else $error("done and changed reported together");

  a_lamp_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && lamp_on |-> done_res)
    else $error("lamp_on outside a done result");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_on_follows_done: assert property (@(posedge clk) disable iff (rst)
    $changed(on_flag) |-> $past(state) == S_STEP)
    else $error("on state changed outside a settle step");
`endif

endmodule

`default_nettype wire

// File: rtl/cctmix_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle, QUO_W quotient bits per divide.
module cctmix_div #(
  parameter int NUM_W = cctmix_pkg::NUM_W,
  parameter int DEN_W = cctmix_pkg::DEN_W,
  parameter int QUO_W = cctmix_pkg::QUO_W
) (
  input  wire                   clk,
  input  wire                   rst,
  input  cctmix_pkg::div_req_t  req,
  output cctmix_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.num;
        dsh  <= NUM_W'(req.den) << (QUO_W - 1);
        quo  <= '0;
        cnt  <= CNT_W'(QUO_W);
        busy <= 1'b1;
      end else if (busy) begin
        // compare, subtract, shift the divisor down one place
        if (ge) begin
          rem <= rem - dsh;
        end
        quo <= {quo[QUO_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
  import cctmix_pkg::*;

  // Codes the package leaves unnamed: the spare item code and the spare register slot.
  localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int KELVIN_MAX   = (1 << KELVIN_W) - 1;
  localparam int LEVEL_MAX    = (1 << LVL_W) - 1;
  // Long enough for a pending tick to finish, with some margin on top.
  localparam int DRAIN_CYCLES = 40;
  // A cap on the whole run, with a wide margin.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PRINT_CAP    = 50;

  // One result, with its fields in port order.
  typedef struct packed {
    logic [DUTY_W-1:0]   cool;
    logic [DUTY_W-1:0]   warm;
    logic                changed;
    logic                slow;
    logic                done;
    logic                lamp;
    logic [KELVIN_W-1:0] kel;
    logic [LVL_W-1:0]    bri;
  } mix_out_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                req_valid;
  logic                req_stall;
  logic [OP_W-1:0]     op;
  logic [KELVIN_W-1:0] kelvin;
  logic [BRI_W-1:0]    brightness;
  logic                res_valid;
  logic                res_stall;
  logic [DUTY_W-1:0]   duty_cool;
  logic [DUTY_W-1:0]   duty_warm;
  logic                changed;
  logic                slow_hold;
  logic                done_res;
  logic                lamp_on;
  logic [KELVIN_W-1:0] app_kelvin_out;
  logic [LVL_W-1:0]    app_brightness_out;

  // Mixer state as this bench tracks it: the registers, the kept request, the fade
  // target and the present duties.
  logic [KELVIN_W-1:0] warm_k, cool_k, kept_kelvin, aim_kelvin;
  logic [LVL_W-1:0]    floor_bri, kept_bri, aim_level;
  logic [DUTY_W-1:0]   cool_duty, warm_duty;
  logic                fading, lit;

  mix_out_t    expected_mix[$];
  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cycles       = 0;
  // When set, neither side inserts idle cycles.
  bit          no_gaps      = 1'b0;

  cct_led_mixer_fader_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .req_valid          (req_valid),
    .req_stall          (req_stall),
    .op                 (op),
    .kelvin             (kelvin),
    .brightness         (brightness),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .duty_cool          (duty_cool),
    .duty_warm          (duty_warm),
    .changed            (changed),
    .slow_hold          (slow_hold),
    .done_res           (done_res),
    .lamp_on            (lamp_on),
    .app_kelvin_out     (app_kelvin_out),
    .app_brightness_out (app_brightness_out)
  );

  always #1 clk = ~clk;

  // Round half up, then saturate at full duty.
  function automatic logic [DUTY_W-1:0] duty_of(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > DUTY_FULL) ? DUTY_W'(DUTY_FULL) : DUTY_W'(q);
  endfunction

  // Apply one accepted item to the tracked state and return the result it must give.
  function automatic mix_out_t advance_mixer(input logic [OP_W-1:0]     code,
                                             input logic [KELVIN_W-1:0] k,
                                             input logic [BRI_W-1:0]    b);
    mix_out_t          r;
    longint unsigned   span, kk, lvl;
    logic [DUTY_W-1:0] tc, tw;
    logic              moved;
    r     = '0;
    moved = 1'b0;
    if (code == OP_SET) begin
      // Keep only an in-span kelvin and a brightness of 1 to 100.
      if (k >= warm_k && k <= cool_k) kept_kelvin = k;
      if (b >= 1 && b <= PCT_FULL) kept_bri = b[LVL_W-1:0];
      aim_kelvin = kept_kelvin;
      aim_level  = (kept_bri >= 1 && kept_bri <= floor_bri) ? floor_bri : kept_bri;
      fading     = 1'b1;
    end else if (code == OP_OFF) begin
      aim_kelvin = kept_kelvin;
      aim_level  = '0;
      fading     = 1'b1;
    end else if (code == OP_TICK && fading) begin
      lvl = 64'(aim_level);
      if (cool_k <= warm_k) begin
        // Empty span: everything goes to the warm channel.
        tc = '0;
        tw = duty_of(lvl * DUTY_FULL, 64'(PCT_FULL));
      end else begin
        // Clamp the kept kelvin into the span as it stands now.
        span = 64'(cool_k - warm_k);
        kk   = 64'(aim_kelvin);
        if (kk < warm_k) kk = 64'(warm_k);
        if (kk > cool_k) kk = 64'(cool_k);
        tc = duty_of(lvl * DUTY_FULL * (kk - warm_k), PCT_FULL * span);
        tw = duty_of(lvl * DUTY_FULL * (cool_k - kk), PCT_FULL * span);
      end
      if (cool_duty > tc) begin
        cool_duty = cool_duty - 1'b1;
        moved     = 1'b1;
      end else if (cool_duty < tc) begin
        cool_duty = cool_duty + 1'b1;
        moved     = 1'b1;
      end
      if (warm_duty > tw) begin
        warm_duty = warm_duty - 1'b1;
        moved     = 1'b1;
      end else if (warm_duty < tw) begin
        warm_duty = warm_duty + 1'b1;
        moved     = 1'b1;
      end
      if (moved) begin
        r.changed = 1'b1;
        r.slow    = (int'(cool_duty) + int'(warm_duty) < SLOW_SUM);
      end else begin
        // Both duties already at target: the fade ends here.
        fading = 1'b0;
        lit    = (aim_level != 0);
        r.done = 1'b1;
        r.lamp = lit;
        r.kel  = kept_kelvin;
        r.bri  = kept_bri;
      end
    end
    r.cool = cool_duty;
    r.warm = warm_duty;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    if (errors < PRINT_CAP)
      $display("MISMATCH %s at result %0d: got %0d, want %0d", field, results_seen, got, want);
    errors++;
  endtask

  // Present one item after a random gap, hold it until accepted, and queue the
  // result it must produce. Leave valid high on return; the next call or a drain
  // decides what happens to it, so it never sees two updates in one step.
  task automatic send_item(input logic [OP_W-1:0]     code,
                           input logic [KELVIN_W-1:0] k,
                           input logic [BRI_W-1:0]    b);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    op         <= code;
    kelvin     <= k;
    brightness <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_mix.push_back(advance_mixer(code, k, b));
    items_sent++;
  endtask

  // Drop valid, wait out every outstanding result, then let the block go quiet.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back, plus a throwaway write to the spare
  // slot. The floor write carries random upper bits that the block must drop.
  task automatic write_regs(input logic [KELVIN_W-1:0] warm_v,
                            input logic [KELVIN_W-1:0] cool_v,
                            input logic [LVL_W-1:0]    floor_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WARM;
    cfg_data  <= warm_v;
    @(posedge clk);
    cfg_index <= REG_COOL;
    cfg_data  <= cool_v;
    @(posedge clk);
    cfg_index <= REG_MIN_BRI;
    cfg_data  <= {(CFG_W - LVL_W)'($urandom), floor_v};
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    warm_k    = warm_v;
    cool_k    = cool_v;
    floor_bri = floor_v;
  endtask

  // Tick until the fade reports done, or until the cap runs out. The done tick
  // itself is part of the loop, since that is what clears the fade.
  task automatic settle_fade(input int unsigned cap);
    int unsigned n;
    n = 0;
    while (fading && n < cap) begin
      send_item(OP_TICK, KELVIN_W'($urandom), BRI_W'($urandom));
      n++;
    end
  endtask

  // Reset registers: idle ticks, the spare code, off from dark, ignored fields,
  // the floor, and a short fade run to done.
  task automatic test_basic_ops();
    send_item(OP_TICK, '0, '0);                           // nothing pending
    send_item(OP_UNUSED, KELVIN_W'(KELVIN_MAX), 8'hFF);   // spare code acts as idle
    send_item(OP_OFF, '0, '0);
    send_item(OP_TICK, '0, '0);                           // already dark: done, lamp off
    send_item(OP_SET, KELVIN_W'(WARM_RST - 1), BRI_W'(PCT_FULL + 1));  // both out of range
    send_item(OP_TICK, KELVIN_W'(KELVIN_MAX), '0);
    send_item(OP_SET, KELVIN_W'(COOL_RST + 1), '0);       // still ignored
    send_item(OP_SET, WARM_RST, BRI_W'(PCT_FULL));        // edges of both ranges
    send_item(OP_SET, COOL_RST, 8'd1);                    // floor lifts 1 to 5
    settle_fade(40);
  endtask

  // Floor at its top: level 127 at the warm end asks for more than full duty.
  // Run well past the point where a wrapped target would end the fade.
  task automatic test_floor_saturation();
    drain_results();
    write_regs(WARM_RST, COOL_RST, LVL_W'(LEVEL_MAX));
    send_item(OP_SET, WARM_RST, 8'd1);
    settle_fade(80);
  endtask

  // Equal and inverted kelvin limits: all duty on warm; with inverted limits no kelvin is in span.
  task automatic test_empty_span();
    drain_results();
    write_regs(14'd5000, 14'd5000, MIN_BRI_RST);
    send_item(OP_SET, 14'd5000, 8'd20);
    settle_fade(300);
    drain_results();
    write_regs(14'd5000, 14'd4000, MIN_BRI_RST);
    send_item(OP_SET, 14'd4500, 8'd40);
    repeat (10) send_item(OP_TICK, KELVIN_W'($urandom), BRI_W'($urandom));
    send_item(OP_OFF, KELVIN_W'($urandom), BRI_W'($urandom));
    settle_fade(300);
  endtask

  // Keep a kelvin, then move the span so it falls above and then below it.
  task automatic test_kelvin_clamp();
    drain_results();
    write_regs(WARM_RST, COOL_RST, '0);
    send_item(OP_SET, COOL_RST, 8'd10);
    settle_fade(300);
    drain_results();
    write_regs(WARM_RST, 14'd3000, '0);
    send_item(OP_SET, '0, 8'd10);                         // kept 6500 clamps to 3000
    settle_fade(300);
    drain_results();
    write_regs(14'd6600, 14'd9000, '0);
    send_item(OP_SET, '0, 8'd10);                         // kept 6500 clamps to 6600
    settle_fade(300);
  endtask

  // Mostly a set or off followed by a run of ticks, sometimes to done; the rest
  // is random codes with random fields.
  task automatic random_burst(input int unsigned n);
    int unsigned         first, pick, ticks;
    logic [KELVIN_W-1:0] k;
    logic [BRI_W-1:0]    b;
    first = items_sent;
    while (items_sent - first < n) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      pick    = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 7 && cool_k >= warm_k)
        k = KELVIN_W'($urandom_range(warm_k, cool_k));
      else
        k = KELVIN_W'($urandom);
      // Favor small levels so fades settle within a few dozen ticks.
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: b = BRI_W'($urandom_range(1, 15));
        5, 6, 7:       b = BRI_W'($urandom_range(1, PCT_FULL));
        8:             b = ($urandom_range(0, 1) != 0) ? BRI_W'(0)
                                                      : BRI_W'($urandom_range(101, 255));
        default:       b = BRI_W'($urandom);
      endcase
      if (pick < 6)
        send_item(OP_SET, k, b);
      else if (pick < 8)
        send_item(OP_OFF, k, b);
      else
        send_item(OP_W'($urandom), k, b);
      if ($urandom_range(0, 3) == 0) begin
        settle_fade(64);
      end else begin
        ticks = $urandom_range(1, 20);
        repeat (ticks) send_item(OP_TICK, KELVIN_W'($urandom), BRI_W'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Random traffic under several register settings, extremes included.
  task automatic test_random_mix();
    drain_results();
    write_regs(WARM_RST, COOL_RST, MIN_BRI_RST);
    random_burst(50);
    drain_results();
    write_regs('0, KELVIN_W'(KELVIN_MAX), '0);
    random_burst(50);
    drain_results();
    write_regs(KELVIN_W'(KELVIN_MAX), '0, LVL_W'(LEVEL_MAX));
    random_burst(50);
    drain_results();
    write_regs(14'd1000, 14'd10000, LVL_W'(PCT_FULL));
    random_burst(50);
    drain_results();
    write_regs(14'd4000, 14'd4001, 7'd50);
    random_burst(50);
    drain_results();
    write_regs(14'd3000, 14'd3000, 7'd20);
    random_burst(50);
  endtask

  // Result side: stall for a random count before each result, sometimes not at all.
  initial begin : result_side
    int unsigned hold;
    res_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!(res_valid && !res_stall)) @(posedge clk);
    end
  end

  // Compare every accepted result with the oldest one queued.
  always @(posedge clk) begin : check_result
    mix_out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_mix.size() == 0) begin
        flag_mismatch("unexpected result", longint'(1), longint'(0));
      end else begin
        want = expected_mix.pop_front();
        if (duty_cool !== want.cool)
          flag_mismatch("duty_cool", longint'(duty_cool), longint'(want.cool));
        if (duty_warm !== want.warm)
          flag_mismatch("duty_warm", longint'(duty_warm), longint'(want.warm));
        if (changed !== want.changed)
          flag_mismatch("changed", longint'(changed), longint'(want.changed));
        if (slow_hold !== want.slow)
          flag_mismatch("slow_hold", longint'(slow_hold), longint'(want.slow));
        if (done_res !== want.done)
          flag_mismatch("done_res", longint'(done_res), longint'(want.done));
        if (lamp_on !== want.lamp)
          flag_mismatch("lamp_on", longint'(lamp_on), longint'(want.lamp));
        if (app_kelvin_out !== want.kel)
          flag_mismatch("app_kelvin_out", longint'(app_kelvin_out), longint'(want.kel));
        if (app_brightness_out !== want.bri)
          flag_mismatch("app_brightness_out", longint'(app_brightness_out),
                        longint'(want.bri));
      end
      results_seen++;
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("cct_led_mixer_fader_core verification failed");
      $finish;
    end
  end

  initial begin
    // Drive every input from time zero and hold reset before the tests start.
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_WARM;
    cfg_data   <= '0;
    req_valid  <= 1'b0;
    op         <= OP_TICK;
    kelvin     <= '0;
    brightness <= '0;
    // Tracked state starts at the reset values.
    warm_k      = WARM_RST;
    cool_k      = COOL_RST;
    floor_bri   = MIN_BRI_RST;
    kept_kelvin = WARM_RST;
    kept_bri    = APP_BRI_RST;
    aim_kelvin  = WARM_RST;
    aim_level   = '0;
    fading      = 1'b0;
    cool_duty   = '0;
    warm_duty   = '0;
    lit         = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_floor_saturation();
    test_empty_span();
    test_kelvin_clamp();
    test_random_mix();
    drain_results();

    if (errors == 0 && expected_mix.size() == 0)
      $display("cct_led_mixer_fader_core verification clean");
    else
      $display("cct_led_mixer_fader_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
